[hw/rtl/suis_pkg.sv]
package suis_pkg;

    // List size and derived widths
    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths
    localparam int ACT_W = 2;
    localparam int VAL_W = 32;
    localparam int IDX_W = 8;
    localparam int ST_W  = 2;
    localparam int POS_W = 8;
    localparam int EC_W  = 9;

    // Request actions (code 3 is unused and ignored)
    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_READ   = 2'd2
    } t_action;

    // Response status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Which response the datapath builds
    typedef enum logic [2:0] {
        RES_CLEAR = 3'd0,
        RES_DUP   = 3'd1,
        RES_FULL  = 3'd2,
        RES_INS   = 3'd3,
        RES_READ  = 3'd4,
        RES_RANGE = 3'd5,
        RES_NOP   = 3'd6
    } t_res_kind;

    // Controller -> datapath commands
    typedef struct packed {
        logic      take_req;   // latch request, start search window
        logic      clear;      // empty the list
        logic      srch_rd;    // read entry at window midpoint
        logic      srch_cmp;   // narrow window from compare
        logic      shift_init; // start shift from top of list
        logic      shift_step; // move one entry up, or drop value in
        logic      rd_issue;   // read entry at request index
        logic      res_load;   // load response register
        t_res_kind res_kind;
    } t_dp_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             lo_lt_hi;
        logic             match;
        logic             full;
        logic             shift_more;
        logic             shift_pend;
        logic             idx_ok;
        logic             out_free;
    } t_dp_sts;

endpackage

[hw/rtl/suis_if.sv]
// Request channel
interface suis_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] value;
    logic [7:0]  index;

    modport source (output valid, action, value, index, input ready);
    modport sink   (input valid, action, value, index, output ready);
endinterface

// Response channel
interface suis_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  position;
    logic [8:0]  entry_count;
    logic [31:0] read_value;

    modport source (output valid, status, position, entry_count, read_value, input ready);
    modport sink   (input valid, status, position, entry_count, read_value, output ready);
endinterface

[hw/rtl/sorted_unique_set_insert_unit.sv]
// Request accept to response valid: clear, unused action and out-of-range read go from
//   S_DECODE to S_DONE; read adds S_RDWAIT; insert binary-searches the n stored entries
//   (each probe S_SRCH then S_CMP) and, with no duplicate and a free slot, shifts one entry
//   per cycle and writes the value. One request in flight; none is taken until the response
//   is loaded. The registered read port of the list memory sets the pace of search and shift.
// Reset: synchronous active low; empties the list and clears control, memory not swept.
module sorted_unique_set_insert_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    suis_req_if.sink   i_req,
    suis_rsp_if.source o_rsp
);

    suis_pkg::t_dp_cmd w_cmd;
    suis_pkg::t_dp_sts w_sts;
    logic              w_req_ready;

    assign i_req.ready = w_req_ready;

    // sequencer
    suis_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // list memory, search window and response register
    suis_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_action      (i_req.action),
        .i_value       (i_req.value),
        .i_index       (i_req.index),
        .i_rsp_ready   (o_rsp.ready),
        .o_rsp_valid   (o_rsp.valid),
        .o_status      (o_rsp.status),
        .o_position    (o_rsp.position),
        .o_entry_count (o_rsp.entry_count),
        .o_read_value  (o_rsp.read_value)
    );

endmodule

[hw/rtl/suis_ram.sv]
module suis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; read data holds without i_re
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/suis_datapath.sv]
module suis_datapath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  suis_pkg::t_dp_cmd        i_cmd,
    output suis_pkg::t_dp_sts        o_sts,
    // request payload
    input  logic [suis_pkg::ACT_W-1:0] i_action,
    input  logic [suis_pkg::VAL_W-1:0] i_value,
    input  logic [suis_pkg::IDX_W-1:0] i_index,
    // response register
    input  logic                     i_rsp_ready,
    output logic                     o_rsp_valid,
    output logic [suis_pkg::ST_W-1:0]  o_status,
    output logic [suis_pkg::POS_W-1:0] o_position,
    output logic [suis_pkg::EC_W-1:0]  o_entry_count,
    output logic [suis_pkg::VAL_W-1:0] o_read_value
);

    localparam int AW   = suis_pkg::ADDR_W;
    localparam int CW   = suis_pkg::CNT_W;
    localparam int VW   = suis_pkg::VAL_W;
    localparam int IW   = suis_pkg::IDX_W;
    localparam int PW   = suis_pkg::POS_W;
    localparam int EW   = suis_pkg::EC_W;
    localparam int CMPW = CW + IW;

    // request fields
    logic [suis_pkg::ACT_W-1:0] r_action;
    logic [VW-1:0]              r_value;
    logic [IW-1:0]              r_index;

    // search window, shift pointer, list count
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [AW-1:0] r_mid, n_mid;
    logic [AW-1:0] r_j, n_j;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_pend_addr, n_pend_addr;
    logic [CW-1:0] r_count, n_count;

    // response register
    logic                      r_out_valid, n_out_valid;
    logic [suis_pkg::ST_W-1:0] r_status, n_status;
    logic [PW-1:0]             r_position, n_position;
    logic [EW-1:0]             r_entry_count, n_entry_count;
    logic [VW-1:0]             r_read_value, n_read_value;

    // memory ports
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [VW-1:0] w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [VW-1:0] w_rdata;

    logic [CW-1:0] w_mid;
    logic          w_shift_more;

    suis_ram #(
        .WIDTH (VW),
        .DEPTH (suis_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_mid        = r_lo + ((r_hi - r_lo) >> 1);
    assign w_shift_more = CW'(r_j) > r_lo;

    // status to controller
    always_comb begin
        o_sts.action     = r_action;
        o_sts.lo_lt_hi   = r_lo < r_hi;
        o_sts.match      = w_rdata == r_value;
        o_sts.full       = r_count >= CW'(suis_pkg::CAPACITY);
        o_sts.shift_more = w_shift_more;
        o_sts.shift_pend = r_pend;
        o_sts.idx_ok     = CMPW'(r_index) < CMPW'(r_count);
        o_sts.out_free   = !r_out_valid || i_rsp_ready;
    end

    // search, shift and memory control
    always_comb begin
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_j         = r_j;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_count     = r_count;
        w_we        = 1'b0;
        w_waddr     = r_pend_addr;
        w_wdata     = w_rdata;
        w_re        = 1'b0;
        w_raddr     = AW'(w_mid);

        if (i_cmd.take_req) begin
            n_lo = '0;
            n_hi = r_count;
        end
        if (i_cmd.clear) begin
            n_count = '0;
        end
        if (i_cmd.srch_rd) begin
            w_re  = 1'b1;
            n_mid = AW'(w_mid);
        end
        // entry below value: move low bound past midpoint, else pull high bound down
        if (i_cmd.srch_cmp) begin
            if (w_rdata < r_value) begin
                n_lo = CW'(r_mid) + CW'(1);
            end else begin
                n_hi = CW'(r_mid);
            end
        end
        if (i_cmd.shift_init) begin
            n_j    = AW'(r_count);
            n_pend = 1'b0;
        end
        // read entry j-1 while writing the previous read into its new slot
        if (i_cmd.shift_step) begin
            if (r_pend) begin
                w_we    = 1'b1;
                w_waddr = r_pend_addr;
                w_wdata = w_rdata;
            end
            if (w_shift_more) begin
                w_re        = 1'b1;
                w_raddr     = r_j - AW'(1);
                n_pend      = 1'b1;
                n_pend_addr = r_j;
                n_j         = r_j - AW'(1);
            end else begin
                n_pend = 1'b0;
                if (!r_pend) begin
                    w_we    = 1'b1;
                    w_waddr = AW'(r_lo);
                    w_wdata = r_value;
                    n_count = r_count + CW'(1);
                end
            end
        end
        if (i_cmd.rd_issue) begin
            w_re    = 1'b1;
            w_raddr = AW'(r_index);
        end
    end

    // response build
    always_comb begin
        n_out_valid   = r_out_valid;
        n_status      = r_status;
        n_position    = r_position;
        n_entry_count = r_entry_count;
        n_read_value  = r_read_value;
        if (r_out_valid && i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.res_load) begin
            n_out_valid   = 1'b1;
            n_entry_count = EW'(r_count);
            n_position    = '0;
            n_read_value  = '0;
            unique case (i_cmd.res_kind)
                suis_pkg::RES_DUP: begin
                    n_status   = suis_pkg::ST_DUP;
                    n_position = PW'(r_mid);
                end
                suis_pkg::RES_FULL: begin
                    n_status = suis_pkg::ST_FULL;
                end
                suis_pkg::RES_INS: begin
                    n_status   = suis_pkg::ST_OK;
                    n_position = PW'(r_lo);
                end
                suis_pkg::RES_READ: begin
                    n_status     = suis_pkg::ST_OK;
                    n_position   = PW'(r_index);
                    n_read_value = w_rdata;
                end
                suis_pkg::RES_RANGE: begin
                    n_status   = suis_pkg::ST_RANGE;
                    n_position = PW'(r_index);
                end
                default: begin
                    n_status = suis_pkg::ST_OK;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_action <= i_action;
            r_value  <= i_value;
            r_index  <= i_index;
        end
        r_lo          <= n_lo;
        r_hi          <= n_hi;
        r_mid         <= n_mid;
        r_j           <= n_j;
        r_pend_addr   <= n_pend_addr;
        r_status      <= n_status;
        r_position    <= n_position;
        r_entry_count <= n_entry_count;
        r_read_value  <= n_read_value;
    end

    assign o_rsp_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_position    = r_position;
    assign o_entry_count = r_entry_count;
    assign o_read_value  = r_read_value;

endmodule

[hw/rtl/suis_ctrl.sv]
module suis_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  suis_pkg::t_dp_sts i_sts,
    output suis_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_SRCH   = 7'b0000100,
        S_CMP    = 7'b0001000,
        S_SHIFT  = 7'b0010000,
        S_RDWAIT = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    suis_pkg::t_res_kind r_kind, n_kind;

    assign o_req_ready = r_state == S_IDLE;

    // next state and commands
    always_comb begin
        n_state        = r_state;
        n_kind         = r_kind;
        o_cmd          = '0;
        o_cmd.res_kind = r_kind;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.take_req = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.action)
                    suis_pkg::ACT_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        n_kind      = suis_pkg::RES_CLEAR;
                        n_state     = S_DONE;
                    end
                    suis_pkg::ACT_INSERT: begin
                        n_state = S_SRCH;
                    end
                    suis_pkg::ACT_READ: begin
                        if (i_sts.idx_ok) begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = S_RDWAIT;
                        end else begin
                            n_kind  = suis_pkg::RES_RANGE;
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        n_kind  = suis_pkg::RES_NOP;
                        n_state = S_DONE;
                    end
                endcase
            end
            // window open: probe midpoint; closed: value absent
            S_SRCH: begin
                if (i_sts.lo_lt_hi) begin
                    o_cmd.srch_rd = 1'b1;
                    n_state       = S_CMP;
                end else if (i_sts.full) begin
                    n_kind  = suis_pkg::RES_FULL;
                    n_state = S_DONE;
                end else begin
                    o_cmd.shift_init = 1'b1;
                    n_state          = S_SHIFT;
                end
            end
            S_CMP: begin
                if (i_sts.match) begin
                    n_kind  = suis_pkg::RES_DUP;
                    n_state = S_DONE;
                end else begin
                    o_cmd.srch_cmp = 1'b1;
                    n_state        = S_SRCH;
                end
            end
            // last step writes the new value once the shift has drained
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (!i_sts.shift_more && !i_sts.shift_pend) begin
                    n_kind  = suis_pkg::RES_INS;
                    n_state = S_DONE;
                end
            end
            S_RDWAIT: begin
                n_kind  = suis_pkg::RES_READ;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= suis_pkg::RES_NOP;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

endmodule

[hw/rtl/suis_checker.sv]
module suis_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_status,
    input logic [7:0]  i_position,
    input logic [8:0]  i_entry_count,
    input logic [31:0] i_read_value
);

    localparam logic [8:0] CAP_EC = 9'(suis_pkg::CAPACITY);

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status)
            && $stable(i_position) && $stable(i_entry_count) && $stable(i_read_value))
        else $error("response changed while stalled");

    // a dropped insert only happens on a full list
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status == suis_pkg::ST_FULL |-> i_entry_count == CAP_EC
            && i_position == 8'd0 && i_read_value == 32'd0)
        else $error("full status without a full list");

    // data only comes back on a successful request
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_read_value != 32'd0 |-> i_status == suis_pkg::ST_OK)
        else $error("read data on a failed request");

    // count never passes the list size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_entry_count <= CAP_EC)
        else $error("entry count beyond capacity");

endmodule

bind sorted_unique_set_insert_unit suis_checker u_suis_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_status      (o_rsp.status),
    .i_position    (o_rsp.position),
    .i_entry_count (o_rsp.entry_count),
    .i_read_value  (o_rsp.read_value)
);

[bench/sorted_unique_set_insert_unit_tb.sv]
`timescale 1ns / 1ps

module sorted_unique_set_insert_unit_tb;
    import suis_pkg::*;

    // Action code 3 is not decoded by the block and must be ignored
    localparam logic [ACT_W-1:0] ACT_RESERVED = 2'd3;

    localparam int IDLE_PCT       = 33;
    localparam int STALL_LIMIT    = 20000;
    localparam int LONG_HOLD      = 600;
    localparam int DRAIN_CYCLES   = 400;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int STEADY_ITEMS   = 300;

    typedef struct packed {
        t_status           status;
        logic [POS_W-1:0]  position;
        logic [EC_W-1:0]   entry_count;
        logic [VAL_W-1:0]  read_value;
    } t_set_rsp;

    logic i_clk;
    logic i_rst_n;

    suis_req_if req_ch ();
    suis_rsp_if rsp_ch ();

    sorted_unique_set_insert_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow copy of the sorted list
    logic [VAL_W-1:0] shadow_list [CAPACITY];
    int unsigned      shadow_count;

    t_set_rsp expected_set_rsps [$];
    int       error_count;
    int       stall_cycles;
    bit       no_idle;
    int       rsp_hold_cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Predict the response of one request and update the shadow list
    function automatic t_set_rsp predict_set_op(input logic [ACT_W-1:0] act,
                                                input logic [VAL_W-1:0] val,
                                                input logic [IDX_W-1:0] idx);
        t_set_rsp    r;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        bit          found;
        r     = '0;
        found = 1'b0;
        case (act)
            ACT_CLEAR: begin
                shadow_count = 0;
            end
            ACT_INSERT: begin
                lo = 0;
                hi = shadow_count;
                while (lo < hi && !found) begin
                    mid = lo + ((hi - lo) >> 1);
                    if (shadow_list[mid] == val) begin
                        found = 1'b1;
                        lo    = mid;
                    end else if (shadow_list[mid] < val) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid;
                    end
                end
                if (found) begin
                    r.status   = ST_DUP;
                    r.position = lo[POS_W-1:0];
                end else if (shadow_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (int j = shadow_count; j > lo; j--)
                        shadow_list[j] = shadow_list[j-1];
                    shadow_list[lo] = val;
                    shadow_count++;
                    r.status   = ST_OK;
                    r.position = lo[POS_W-1:0];
                end
            end
            ACT_READ: begin
                r.position = idx;
                if (idx < shadow_count) begin
                    r.status     = ST_OK;
                    r.read_value = shadow_list[idx];
                end else begin
                    r.status = ST_RANGE;
                end
            end
            default: ;
        endcase
        r.entry_count = shadow_count[EC_W-1:0];
        return r;
    endfunction

    function automatic bit shadow_holds(input logic [VAL_W-1:0] val);
        for (int j = 0; j < shadow_count; j++)
            if (shadow_list[j] == val)
                return 1'b1;
        return 1'b0;
    endfunction

    // Insert value biased toward duplicates and the ends of the range
    function automatic logic [VAL_W-1:0] pick_insert_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (shadow_count > 0 && roll < 30)
            return shadow_list[$urandom_range(shadow_count - 1)];
        if (roll < 45)
            return $urandom_range(31);
        if (roll < 55)
            return 32'hFFFF_FFFF - $urandom_range(31);
        return $urandom();
    endfunction

    function automatic int idle_gap();
        int g;
        g = 0;
        if (!no_idle)
            while ($urandom_range(99) < IDLE_PCT)
                g++;
        return g;
    endfunction

    // Offer one request, wait for it to be taken, record the expected response
    task automatic send_request(input logic [ACT_W-1:0] act,
                                input logic [VAL_W-1:0] val,
                                input logic [IDX_W-1:0] idx);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.value  <= val;
        req_ch.index  <= idx;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        expected_set_rsps.push_back(predict_set_op(act, val, idx));
    endtask

    // Sender pauses until every outstanding response is back
    task automatic wait_for_responses();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_set_rsps.size() > 0);
    endtask

    task automatic send_random_request();
        int unsigned roll;
        roll = $urandom_range(199);
        if (roll < 2)
            send_request(ACT_CLEAR, $urandom(), IDX_W'($urandom()));
        else if (roll < 8)
            send_request(ACT_RESERVED, $urandom(), IDX_W'($urandom()));
        else if (roll < 130)
            send_request(ACT_INSERT, pick_insert_value(), IDX_W'($urandom()));
        else if (roll < 180)
            send_request(ACT_READ, $urandom(), IDX_W'($urandom_range(shadow_count)));
        else
            send_request(ACT_READ, $urandom(), IDX_W'($urandom_range(255)));
    endtask

    // Field extremes, zero as a real value, duplicates, reads past the end
    task automatic test_directed();
        send_request(ACT_CLEAR, 32'hFFFF_FFFF, 8'hFF);
        send_request(ACT_READ, 32'h0, 8'd0);
        send_request(ACT_READ, 32'hFFFF_FFFF, 8'hFF);
        send_request(ACT_INSERT, 32'h0, 8'hFF);
        send_request(ACT_INSERT, 32'h0, 8'h0);
        send_request(ACT_INSERT, 32'hFFFF_FFFF, 8'h0);
        send_request(ACT_INSERT, 32'h8000_0000, 8'h0);
        send_request(ACT_INSERT, 32'h1, 8'h0);
        send_request(ACT_INSERT, 32'h7FFF_FFFF, 8'h0);
        send_request(ACT_INSERT, 32'hFFFF_FFFE, 8'h0);
        send_request(ACT_READ, 32'h0, 8'd0);
        send_request(ACT_READ, 32'h0, 8'd5);
        send_request(ACT_READ, 32'h0, 8'd6);
        send_request(ACT_INSERT, 32'hFFFF_FFFF, 8'h0);
        send_request(ACT_RESERVED, 32'hFFFF_FFFF, 8'hFF);
        send_request(ACT_RESERVED, 32'h0, 8'h0);
        send_request(ACT_CLEAR, 32'h0, 8'h0);
        send_request(ACT_READ, 32'h0, 8'd0);
        send_request(ACT_INSERT, 32'd5, 8'h0);
        send_request(ACT_READ, 32'h0, 8'd0);
        send_request(ACT_INSERT, 32'd3, 8'h0);
        send_request(ACT_INSERT, 32'd9, 8'h0);
        send_request(ACT_READ, 32'h0, 8'd2);
    endtask

    // Fill to capacity, then full drop versus duplicate on a full list
    task automatic test_full_list();
        logic [VAL_W-1:0] v;
        send_request(ACT_CLEAR, $urandom(), IDX_W'($urandom()));
        while (shadow_count < CAPACITY)
            send_request(ACT_INSERT, $urandom(), IDX_W'($urandom()));
        for (int k = 0; k < 3; k++) begin
            do v = $urandom(); while (shadow_holds(v));
            send_request(ACT_INSERT, v, IDX_W'($urandom()));
            send_request(ACT_INSERT, shadow_list[$urandom_range(CAPACITY - 1)],
                         IDX_W'($urandom()));
        end
        send_request(ACT_INSERT, shadow_list[0], 8'h0);
        send_request(ACT_INSERT, shadow_list[CAPACITY-1], 8'h0);
        send_request(ACT_READ, 32'h0, 8'd0);
        send_request(ACT_READ, 32'hFFFF_FFFF, 8'd255);
        send_request(ACT_READ, 32'h0, IDX_W'($urandom()));
        send_request(ACT_RESERVED, $urandom(), IDX_W'($urandom()));
        wait_for_responses();
        send_request(ACT_CLEAR, $urandom(), IDX_W'($urandom()));
    endtask

    // Response side holds off while requests keep coming, then a full drain
    task automatic test_backpressure();
        no_idle         = 1'b1;
        rsp_hold_cycles = LONG_HOLD;
        for (int k = 0; k < 8; k++)
            send_request(ACT_INSERT, pick_insert_value(), IDX_W'($urandom()));
        no_idle = 1'b0;
        wait_for_responses();
        for (int k = 0; k < 4; k++)
            send_request(ACT_READ, $urandom(), IDX_W'($urandom_range(shadow_count)));
    endtask

    // Random mix with occasional pauses for the list to drain
    task automatic test_random_mix();
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            send_random_request();
            if ($urandom_range(99) == 0)
                wait_for_responses();
        end
    endtask

    // Back-to-back requests with the response side always ready
    task automatic test_steady_stream();
        no_idle = 1'b1;
        for (int k = 0; k < STEADY_ITEMS; k++)
            send_random_request();
        no_idle = 1'b0;
    endtask

    // Response ready: random, or held low for a counted stretch on request
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_hold_cycles > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (rsp_hold_cycles) @(posedge i_clk);
                rsp_hold_cycles = 0;
            end else begin
                rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Compare each response with the oldest expectation
    always @(posedge i_clk) begin : check_rsp
        t_set_rsp exp_rsp;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_set_rsps.size() == 0) begin
                $error("unexpected response: status %0d position %0d count %0d value %0h",
                       rsp_ch.status, rsp_ch.position, rsp_ch.entry_count,
                       rsp_ch.read_value);
                error_count++;
            end else begin
                exp_rsp = expected_set_rsps.pop_front();
                if (rsp_ch.status !== exp_rsp.status) begin
                    $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.position !== exp_rsp.position) begin
                    $error("position: expected %0d, actual %0d",
                           exp_rsp.position, rsp_ch.position);
                    error_count++;
                end
                if (rsp_ch.entry_count !== exp_rsp.entry_count) begin
                    $error("entry_count: expected %0d, actual %0d",
                           exp_rsp.entry_count, rsp_ch.entry_count);
                    error_count++;
                end
                if (rsp_ch.read_value !== exp_rsp.read_value) begin
                    $error("read_value: expected %08h, actual %08h",
                           exp_rsp.read_value, rsp_ch.read_value);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no request or response taken
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.action   = ACT_CLEAR;
        req_ch.value    = '0;
        req_ch.index    = '0;
        shadow_count    = 0;
        error_count     = 0;
        stall_cycles    = 0;
        no_idle         = 1'b0;
        rsp_hold_cycles = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_list();
        test_backpressure();
        test_random_mix();
        test_steady_stream();

        wait_for_responses();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/suis_pkg.sv
hw/rtl/suis_if.sv
hw/rtl/suis_ram.sv
hw/rtl/suis_datapath.sv
hw/rtl/suis_ctrl.sv
hw/rtl/sorted_unique_set_insert_unit.sv
hw/rtl/suis_checker.sv
bench/sorted_unique_set_insert_unit_tb.sv
